[rtl/core/rhff_pkg.sv]
// ----------------------------------------------------------------------------
// rhff_pkg: shared types, constants and saturating helpers
// Word sizes, register codes and the fixed-point helpers used by the
// radiation HLL face flux datapath.
// ----------------------------------------------------------------------------
package rhff_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int WORD_BITS     = 64;
    localparam int HALF_BITS     = WORD_BITS / 2;
    localparam int DIV_BITS      = WORD_BITS + FRACTION_BITS;
    localparam int LIGHT_BITS    = 31;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    localparam logic [LIGHT_BITS-1:0] LIGHT_RESET = LIGHT_BITS'(65536);

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_uword;

    typedef struct packed {
        t_word value;
        logic  clip;
    } t_sat;

    // sideband that travels next to the divider
    typedef struct packed {
        logic  negd;
        logic  is_div;
        t_word sel;
        logic  clip_any;
        logic  clip_div;
    } t_side;

    typedef enum logic {
        REG_LIGHT = 1'b0,
        REG_MODE  = 1'b1
    } t_reg;

    localparam t_word W_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word W_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word VAL_MAX = (t_word'(1) <<< (VALUE_BITS-1)) - t_word'(1);
    localparam t_word VAL_MIN = -VAL_MAX - t_word'(1);

    localparam logic [2*WORD_BITS-1:0] Q_ROUND =
        (2*WORD_BITS)'(1) << (FRACTION_BITS-1);

    function automatic t_sat sat_add(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r.clip  = 1'b1;
            r.value = s[WORD_BITS] ? W_MIN : W_MAX;
        end else begin
            r.clip  = 1'b0;
            r.value = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_sub(t_word a, t_word b);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r.clip  = 1'b1;
            r.value = s[WORD_BITS] ? W_MIN : W_MAX;
        end else begin
            r.clip  = 1'b0;
            r.value = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_uword mag(t_word x);
        t_uword r;
        r = x[WORD_BITS-1] ? t_uword'(~x + 1'b1) : t_uword'(x);
        return r;
    endfunction

    // signed result from sign and magnitude, clipped to the word
    function automatic t_sat from_mag(logic neg, logic hi_nz, t_uword lo);
        t_uword lim;
        t_sat   r;
        lim = neg ? t_uword'(W_MIN) : t_uword'(W_MAX);
        if (hi_nz || lo > lim) begin
            r.clip  = 1'b1;
            r.value = neg ? W_MIN : W_MAX;
        end else begin
            r.clip  = 1'b0;
            r.value = neg ? t_word'(~lo + 1'b1) : t_word'(lo);
        end
        return r;
    endfunction

endpackage

[rtl/core/rhff_if.sv]
// ----------------------------------------------------------------------------
// rhff_if: item and result channels
// Valid/ready channels carrying one face component and its flux result.
// ----------------------------------------------------------------------------
interface rhff_in_if;
    import rhff_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         command;
    logic signed [VALUE_BITS-1:0] left_value;
    logic signed [VALUE_BITS-1:0] right_value;
    logic signed [VALUE_BITS-1:0] left_drive;
    logic signed [VALUE_BITS-1:0] right_drive;
    logic signed [VALUE_BITS-1:0] face_velocity;
    logic signed [VALUE_BITS-1:0] left_gas_velocity;
    logic signed [VALUE_BITS-1:0] right_gas_velocity;

    modport source (
        output valid, command, left_value, right_value, left_drive, right_drive,
               face_velocity, left_gas_velocity, right_gas_velocity,
        input  ready
    );
    modport sink (
        input  valid, command, left_value, right_value, left_drive, right_drive,
               face_velocity, left_gas_velocity, right_gas_velocity,
        output ready
    );
endinterface

interface rhff_out_if;
    import rhff_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] flux_value;
    logic                         negative_density;
    logic                         saturated;

    modport source (
        output valid, flux_value, negative_density, saturated,
        input  ready
    );
    modport sink (
        input  valid, flux_value, negative_density, saturated,
        output ready
    );
endinterface

[rtl/core/radiation_hll_face_flux_top.sv]
// ----------------------------------------------------------------------------
// radiation_hll_face_flux_top: HLL face flux for two-moment radiation
// Streams face components and returns one interface flux for each.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  carries one component of one frequency bin: command, left/right
//         conserved value, left/right drive, face and gas velocities.
//   o_out carries the flux, a negative-density flag and a saturation flag.
//   The APB port sets light_speed (0x0) and comoving_mode (0x4); pready is
//   always high. Write them only while no item is in flight.
// Throughput: one item per cycle while o_out is not stalled. Each result
//   passes through the nine arithmetic stages, the divider's input register,
//   the 80-stage bit-per-stage divider, the divider's output register and
//   the output register.
// Reset (synchronous, active low) clears all valid bits and sets
//   light_speed to 1.0 and comoving_mode to 0.
// Stall: when a result waits at o_out without ready, the whole pipeline
//   holds and i_in.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module radiation_hll_face_flux_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rhff_in_if.sink                          i_in,
    rhff_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rhff_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [rhff_pkg::DATA_BITS-1:0]   pwdata,
    output logic [rhff_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);
    import rhff_pkg::*;

    logic [LIGHT_BITS-1:0] r_light;
    logic                  r_mode;
    logic                  ce;
    t_word                 c_w;

    // stage 0
    logic  r0_v, r0_cmd, r0_negd;
    t_word r0_ul, r0_ur, r0_dl, r0_dr, r0_w, r0_vl, r0_vr;
    // stage 1
    logic  r1_v, r1_cmd, r1_negd, r1_ca, r1_cd;
    t_word r1_dl, r1_dr, r1_sp, r1_sm, r1_du;
    t_sat  sp_s, sm_s, du_s;
    // stage 2
    logic  r2_v, r2_cmd, r2_negd, r2_ca, r2_cd;
    t_word r2_dl, r2_dr, r2_sp, r2_sm, r2_du, r2_den;
    t_sat  den_s;
    // stage 3
    logic  r3_v, r3_cmd, r3_negd, r3_ca, r3_cd;
    t_word r3_dl, r3_dr, r3_sp, r3_sm, r3_du, r3_den, r3_pl, r3_pr;
    // stage 4
    logic  r4_v, r4_cmd, r4_negd, r4_ca, r4_cd;
    t_word r4_dl, r4_dr, r4_sp, r4_sm, r4_den, r4_pl, r4_pr;
    t_word drive_l, drive_r;
    t_sat  fl_s, fr_s;
    // stage 5
    logic  r5_v, r5_negd, r5_ca, r5_cd;
    t_word r5_sp, r5_sm, r5_den, r5_fl, r5_fr;
    // stage 6
    logic  r6_v, r6_negd, r6_ca, r6_cd, r6_isdiv;
    t_word r6_den, r6_g, r6_sel;
    // stage 7
    logic  r7_v, r7_negd, r7_ca, r7_cd, r7_isdiv;
    t_word r7_den, r7_g, r7_sel;
    t_sat  n1_s;
    // stage 8
    logic  r8_v, r8_negd, r8_ca, r8_cd, r8_isdiv;
    t_word r8_den, r8_g, r8_sel, r8_n1;
    t_sat  num_s;
    t_side div_side_in;

    t_sat  p_c2, p_l, p_r, p_spm, p_el, p_er, p_g, p_h, p_i;

    logic  div_v;
    t_sat  div_q;
    t_side div_side;

    t_word n_res;
    logic  n_sat;
    logic  r_out_v, r_out_negd, r_out_sat;
    logic signed [VALUE_BITS-1:0] r_out_flux;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= LIGHT_RESET;
            r_mode  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg'(paddr[ADDR_BITS-1]))
                REG_LIGHT: r_light <= pwdata[LIGHT_BITS-1:0];
                REG_MODE:  r_mode  <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[ADDR_BITS-1]))
            REG_LIGHT: prdata = {{(DATA_BITS-LIGHT_BITS){1'b0}}, r_light};
            REG_MODE:  prdata = {{(DATA_BITS-1){1'b0}}, r_mode};
        endcase
    end

    assign pready = 1'b1;

    // whole pipeline advances unless a result is held at the output
    assign ce         = !r_out_v || o_out.ready;
    assign i_in.ready = ce;
    assign c_w        = t_word'(r_light);

    // ---------------- multipliers ----------------
    rhff_qmul u_mul_c2  (.i_clk, .i_en(ce), .i_a(c_w),        .i_b(c_w),   .o_p(p_c2));
    rhff_qmul u_mul_l   (.i_clk, .i_en(ce), .i_a(r0_ul),      .i_b(r0_vl), .o_p(p_l));
    rhff_qmul u_mul_r   (.i_clk, .i_en(ce), .i_a(r0_ur),      .i_b(r0_vr), .o_p(p_r));
    rhff_qmul u_mul_spm (.i_clk, .i_en(ce), .i_a(r1_sp),      .i_b(r1_sm), .o_p(p_spm));
    rhff_qmul u_mul_el  (.i_clk, .i_en(ce), .i_a(p_c2.value), .i_b(r2_dl), .o_p(p_el));
    rhff_qmul u_mul_er  (.i_clk, .i_en(ce), .i_a(p_c2.value), .i_b(r2_dr), .o_p(p_er));
    rhff_qmul u_mul_g   (.i_clk, .i_en(ce), .i_a(p_spm.value), .i_b(r3_du), .o_p(p_g));
    rhff_qmul u_mul_h   (.i_clk, .i_en(ce), .i_a(r5_sp),      .i_b(r5_fl), .o_p(p_h));
    rhff_qmul u_mul_i   (.i_clk, .i_en(ce), .i_a(r5_sm),      .i_b(r5_fr), .o_p(p_i));

    // ---------------- combinational pieces ----------------
    always_comb begin
        sp_s  = sat_sub(c_w, r0_w);
        sm_s  = sat_sub(-c_w, r0_w);
        du_s  = sat_sub(r0_ur, r0_ul);
        den_s = sat_sub(r1_sp, r1_sm);

        drive_l = r4_cmd ? p_el.value : r4_dl;
        drive_r = r4_cmd ? p_er.value : r4_dr;
        fl_s    = r_mode ? sat_add(drive_l, r4_pl) : sat_sub(drive_l, r4_pl);
        fr_s    = r_mode ? sat_add(drive_r, r4_pr) : sat_sub(drive_r, r4_pr);

        n1_s  = sat_sub(p_h.value, p_i.value);
        num_s = sat_add(r8_n1, r8_g);

        div_side_in.negd     = r8_negd;
        div_side_in.is_div   = r8_isdiv;
        div_side_in.sel      = r8_sel;
        div_side_in.clip_any = r8_ca;
        div_side_in.clip_div = r8_cd | num_s.clip;
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r0_v, r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v} <= '0;
        end else if (ce) begin
            r0_v <= i_in.valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (ce) begin
            // stage 0: capture and widen
            r0_cmd  <= i_in.command;
            r0_negd <= !i_in.command &&
                       (i_in.left_value[VALUE_BITS-1] || i_in.right_value[VALUE_BITS-1]);
            r0_ul   <= t_word'(i_in.left_value);
            r0_ur   <= t_word'(i_in.right_value);
            r0_dl   <= t_word'(i_in.left_drive);
            r0_dr   <= t_word'(i_in.right_drive);
            r0_w    <= t_word'(i_in.face_velocity);
            r0_vl   <= r_mode ? t_word'(i_in.left_gas_velocity)  : t_word'(i_in.face_velocity);
            r0_vr   <= r_mode ? t_word'(i_in.right_gas_velocity) : t_word'(i_in.face_velocity);

            // stage 1: wave speeds
            r1_cmd  <= r0_cmd;
            r1_negd <= r0_negd;
            r1_dl   <= r0_dl;
            r1_dr   <= r0_dr;
            r1_sp   <= sp_s.value;
            r1_sm   <= sm_s.value;
            r1_du   <= du_s.value;
            r1_ca   <= sp_s.clip | sm_s.clip;
            r1_cd   <= du_s.clip;

            // stage 2: divisor
            r2_cmd  <= r1_cmd;
            r2_negd <= r1_negd;
            r2_dl   <= r1_dl;
            r2_dr   <= r1_dr;
            r2_sp   <= r1_sp;
            r2_sm   <= r1_sm;
            r2_du   <= r1_du;
            r2_den  <= den_s.value;
            r2_ca   <= r1_ca;
            r2_cd   <= r1_cd | den_s.clip;

            // stage 3: collect side products
            r3_cmd  <= r2_cmd;
            r3_negd <= r2_negd;
            r3_dl   <= r2_dl;
            r3_dr   <= r2_dr;
            r3_sp   <= r2_sp;
            r3_sm   <= r2_sm;
            r3_du   <= r2_du;
            r3_den  <= r2_den;
            r3_pl   <= p_l.value;
            r3_pr   <= p_r.value;
            r3_ca   <= r2_ca | p_c2.clip | p_l.clip | p_r.clip;
            r3_cd   <= r2_cd;

            // stage 4
            r4_cmd  <= r3_cmd;
            r4_negd <= r3_negd;
            r4_dl   <= r3_dl;
            r4_dr   <= r3_dr;
            r4_sp   <= r3_sp;
            r4_sm   <= r3_sm;
            r4_den  <= r3_den;
            r4_pl   <= r3_pl;
            r4_pr   <= r3_pr;
            r4_ca   <= r3_ca;
            r4_cd   <= r3_cd | p_spm.clip;

            // stage 5: side fluxes
            r5_negd <= r4_negd;
            r5_sp   <= r4_sp;
            r5_sm   <= r4_sm;
            r5_den  <= r4_den;
            r5_fl   <= fl_s.value;
            r5_fr   <= fr_s.value;
            r5_ca   <= r4_ca | (r4_cmd & (p_el.clip | p_er.clip)) | fl_s.clip | fr_s.clip;
            r5_cd   <= r4_cd;

            // stage 6: pick the upwind case
            r6_negd  <= r5_negd;
            r6_den   <= r5_den;
            r6_g     <= p_g.value;
            r6_ca    <= r5_ca;
            r6_cd    <= r5_cd | p_g.clip;
            r6_isdiv <= r5_sm[WORD_BITS-1] &&
                        !(r5_sp[WORD_BITS-1] || r5_sp == '0);
            r6_sel   <= r5_sm[WORD_BITS-1] ? r5_fr : r5_fl;

            // stage 7
            r7_negd  <= r6_negd;
            r7_den   <= r6_den;
            r7_g     <= r6_g;
            r7_ca    <= r6_ca;
            r7_cd    <= r6_cd;
            r7_isdiv <= r6_isdiv;
            r7_sel   <= r6_sel;

            // stage 8: first numerator difference
            r8_negd  <= r7_negd;
            r8_den   <= r7_den;
            r8_g     <= r7_g;
            r8_ca    <= r7_ca;
            r8_cd    <= r7_cd | p_h.clip | p_i.clip | n1_s.clip;
            r8_isdiv <= r7_isdiv;
            r8_sel   <= r7_sel;
            r8_n1    <= n1_s.value;
        end
    end

    // ---------------- divider ----------------
    rhff_div u_div (
        .i_clk,
        .i_rst_n,
        .i_en    (ce),
        .i_valid (r8_v),
        .i_num   (num_s.value),
        .i_den   (r8_den),
        .i_side  (div_side_in),
        .o_valid (div_v),
        .o_quot  (div_q),
        .o_side  (div_side)
    );

    // ---------------- result ----------------
    always_comb begin
        n_res = div_side.is_div ? div_q.value : div_side.sel;
        n_sat = div_side.clip_any |
                (div_side.is_div & (div_side.clip_div | div_q.clip));
        if (n_res > VAL_MAX) begin
            n_res = VAL_MAX;
            n_sat = 1'b1;
        end else if (n_res < VAL_MIN) begin
            n_res = VAL_MIN;
            n_sat = 1'b1;
        end
        // negative density: zero flux, flag only
        if (div_side.negd) begin
            n_res = '0;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_out_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_flux <= n_res[VALUE_BITS-1:0];
            r_out_negd <= div_side.negd;
            r_out_sat  <= n_sat;
        end
    end

    assign o_out.valid            = r_out_v;
    assign o_out.flux_value       = r_out_flux;
    assign o_out.negative_density = r_out_negd;
    assign o_out.saturated        = r_out_sat;

`ifndef SYNTHESIS
    a_negd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_negd |-> r_out_flux == '0 && !r_out_sat)
        else $error("negative density result carries flux or saturation");
`endif

`ifndef SYNTHESIS
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> i_in.ready)
        else $error("input stalled while output register is empty");
`endif

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !o_out.ready |=> r_out_v && $stable(r_out_flux))
        else $error("stalled result changed before its transfer");
`endif

endmodule

[rtl/core/rhff_qmul.sv]
// ----------------------------------------------------------------------------
// rhff_qmul: fixed-point saturating multiplier
// Two-stage product of two words: 32x32 partial products, then a rounded
// shift by the fraction bits and clipping to the word.
// ----------------------------------------------------------------------------
module rhff_qmul (
    input  logic           i_clk,
    input  logic           i_en,
    input  rhff_pkg::t_word i_a,
    input  rhff_pkg::t_word i_b,
    output rhff_pkg::t_sat  o_p
);
    import rhff_pkg::*;

    t_uword                 ma;
    t_uword                 mb;
    t_uword                 r_ll;
    t_uword                 r_lh;
    t_uword                 r_hl;
    t_uword                 r_hh;
    logic                   r_neg;
    logic [2*WORD_BITS-1:0] full;
    logic [2*WORD_BITS-1:0] shifted;
    t_sat                   n_p;
    t_sat                   r_p;

    assign ma = mag(i_a);
    assign mb = mag(i_b);

    always_comb begin
        full = {r_hh, r_ll}
             + {{HALF_BITS{1'b0}}, r_lh, {HALF_BITS{1'b0}}}
             + {{HALF_BITS{1'b0}}, r_hl, {HALF_BITS{1'b0}}}
             + Q_ROUND;
        shifted = full >> FRACTION_BITS;
        n_p = from_mag(r_neg, |shifted[2*WORD_BITS-1:WORD_BITS], shifted[WORD_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= {{HALF_BITS{1'b0}}, ma[HALF_BITS-1:0]} *
                     {{HALF_BITS{1'b0}}, mb[HALF_BITS-1:0]};
            r_lh  <= {{HALF_BITS{1'b0}}, ma[HALF_BITS-1:0]} *
                     {{HALF_BITS{1'b0}}, mb[WORD_BITS-1:HALF_BITS]};
            r_hl  <= {{HALF_BITS{1'b0}}, ma[WORD_BITS-1:HALF_BITS]} *
                     {{HALF_BITS{1'b0}}, mb[HALF_BITS-1:0]};
            r_hh  <= {{HALF_BITS{1'b0}}, ma[WORD_BITS-1:HALF_BITS]} *
                     {{HALF_BITS{1'b0}}, mb[WORD_BITS-1:HALF_BITS]};
            r_neg <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            r_p   <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

[rtl/core/rhff_div.sv]
// ----------------------------------------------------------------------------
// rhff_div: pipelined fixed-point divider
// Restoring division, one quotient bit per stage, then round half away
// from zero and clip. A sideband word travels with each item.
// ----------------------------------------------------------------------------
module rhff_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rhff_pkg::t_word i_num,
    input  rhff_pkg::t_word i_den,
    input  rhff_pkg::t_side i_side,
    output logic            o_valid,
    output rhff_pkg::t_sat  o_quot,
    output rhff_pkg::t_side o_side
);
    import rhff_pkg::*;

    logic [DIV_BITS:0]   r_v;
    t_uword              r_rem  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_nq   [DIV_BITS+1];
    t_uword              r_d    [DIV_BITS+1];
    logic                r_neg  [DIV_BITS+1];
    t_side               r_side [DIV_BITS+1];

    logic [WORD_BITS:0]  n_t    [1:DIV_BITS];
    logic                n_ge   [1:DIV_BITS];
    t_uword              n_rem  [1:DIV_BITS];
    logic [DIV_BITS-1:0] n_nq   [1:DIV_BITS];

    logic                round_up;
    logic [DIV_BITS:0]   q_rnd;
    t_sat                n_quot;

    logic                r_out_v;
    t_sat                r_out_q;
    t_side               r_out_side;

    always_comb begin
        for (int j = 1; j <= DIV_BITS; j++) begin
            n_t[j]   = {r_rem[j-1], r_nq[j-1][DIV_BITS-1]};
            n_ge[j]  = n_t[j] >= {1'b0, r_d[j-1]};
            n_rem[j] = n_ge[j] ? WORD_BITS'(n_t[j] - {1'b0, r_d[j-1]})
                               : n_t[j][WORD_BITS-1:0];
            n_nq[j]  = {r_nq[j-1][DIV_BITS-2:0], n_ge[j]};
        end
    end

    always_comb begin
        round_up = r_rem[DIV_BITS] >= (r_d[DIV_BITS] - r_rem[DIV_BITS]);
        q_rnd    = {1'b0, r_nq[DIV_BITS]} + (DIV_BITS+1)'(round_up);
        n_quot   = from_mag(r_neg[DIV_BITS], |q_rnd[DIV_BITS:WORD_BITS],
                            q_rnd[WORD_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v     <= {r_v[DIV_BITS-1:0], i_valid};
            r_out_v <= r_v[DIV_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= {mag(i_num), {FRACTION_BITS{1'b0}}};
            r_d[0]    <= t_uword'(i_den);
            r_neg[0]  <= i_num[WORD_BITS-1];
            r_side[0] <= i_side;
            for (int j = 1; j <= DIV_BITS; j++) begin
                r_rem[j]  <= n_rem[j];
                r_nq[j]   <= n_nq[j];
                r_d[j]    <= r_d[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_side[j] <= r_side[j-1];
            end
            r_out_q    <= n_quot;
            r_out_side <= r_side[DIV_BITS];
        end
    end

    assign o_valid = r_out_v;
    assign o_quot  = r_out_q;
    assign o_side  = r_out_side;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DIV_BITS] && r_d[DIV_BITS] != '0 |-> r_rem[DIV_BITS] < r_d[DIV_BITS])
        else $error("partial remainder not below divisor");
`endif

endmodule
